// ===== hdl/jsu_pkg.sv =====
// Package for the JSON string unescaper: item types, decoder modes and codes.
// Used by jsu_decode, jsu_outq and the json_string_unescape_utf8 top level.
package jsu_pkg;

    localparam int unsigned MAX_RESULTS = 4;
    localparam int unsigned CNT_W       = 3;

    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_CLOSE = 2'd1;
    localparam logic [1:0] KIND_ERR   = 2'd2;

    localparam logic [2:0] ERR_NO_QUOTE  = 3'd0;
    localparam logic [2:0] ERR_CONTROL   = 3'd1;
    localparam logic [2:0] ERR_ESCAPE    = 3'd2;
    localparam logic [2:0] ERR_HEX       = 3'd3;
    localparam logic [2:0] ERR_SURROGATE = 3'd4;
    localparam logic [2:0] ERR_UNCLOSED  = 3'd5;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6e;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    // Top six bits of a high and of a low surrogate code unit.
    localparam logic [5:0] SURR_HIGH_TAG = 6'b110110;
    localparam logic [5:0] SURR_LOW_TAG  = 6'b110111;

    typedef enum logic [3:0] {
        MODE_IDLE    = 4'd0,
        MODE_STR     = 4'd1,
        MODE_ESC     = 4'd2,
        MODE_HEX1    = 4'd3,
        MODE_WANT_BS = 4'd4,
        MODE_WANT_U  = 4'd5,
        MODE_HEX2    = 4'd6
    } t_mode;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       text_end;
    } t_in_item;

    typedef struct packed {
        logic [1:0] out_kind;
        logic [7:0] out_byte;
        logic [2:0] err_code;
        logic       run_last;
    } t_out_item;

    // All results caused by one input item, lowest index first.
    typedef struct packed {
        logic [CNT_W-1:0]                count;
        t_out_item [MAX_RESULTS-1:0]     items;
    } t_dec_res;

endpackage

// ===== hdl/json_string_unescape_utf8.sv =====
// Top level of the JSON string unescaper to UTF-8 bytes.
// Depends on jsu_pkg, jsu_decode and jsu_outq.
//
//   Channel | Valid        | Stall        | Payload
//   --------+--------------+--------------+--------------------------
//   input   | i_in_valid   | o_in_stall   | i_in_data  (t_in_item)
//   output  | o_out_valid  | i_out_stall  | o_out_data (t_out_item)
//
// One byte is taken per cycle while o_in_stall is low; its results appear in
// the result register on the next cycle, one per cycle while i_out_stall is low.
// The register holds one byte's results, so input stalls until the last goes.
// i_rst_n is synchronous; after it the decoder awaits an opening quote.
// While the output stalls, input is taken only once the register will be empty.
module json_string_unescape_utf8
    import jsu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    logic     in_xfer;
    logic     out_xfer;
    logic     q_valid;
    logic     q_last_going;
    t_dec_res dec_res;

    assign out_xfer   = q_valid && !i_out_stall;
    assign o_in_stall = q_valid && !q_last_going;
    assign in_xfer    = i_in_valid && !o_in_stall;

    jsu_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (in_xfer),
        .i_item  (i_in_data),
        .o_res   (dec_res)
    );

    jsu_outq u_outq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (in_xfer),
        .i_res        (dec_res),
        .i_take       (out_xfer),
        .o_valid      (q_valid),
        .o_last_going (q_last_going),
        .o_item       (o_out_data)
    );

    assign o_out_valid = q_valid;

endmodule

// ===== hdl/jsu_decode.sv =====
// Decoder state and the combinational step that turns one text byte into results.
// Depends on jsu_pkg.
module jsu_decode
    import jsu_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_take,
    input  t_in_item i_item,
    output t_dec_res o_res
);

    t_mode       r_mode, n_mode;
    logic [1:0]  r_hex, n_hex;
    logic [15:0] r_acc, n_acc;
    logic [9:0]  r_held, n_held;

    logic [4:0]  hex_d;
    logic        hex_ok;
    logic [15:0] acc_new;
    logic [4:0]  plane;
    logic        do_fail;
    logic [2:0]  fail_code;
    logic        emit16;
    logic        emit21;
    t_dec_res    res;

    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        case (c) inside
            [8'h30:8'h39]: v = {1'b1, c[3:0]};
            [8'h41:8'h46], [8'h61:8'h66]: v = {1'b1, c[3:0] + 4'd9};
            default: v = 5'd0;
        endcase
        return v;
    endfunction

    assign hex_d   = hex_value(i_item.in_byte);
    assign hex_ok  = hex_d[4] && !i_item.text_end;
    assign acc_new = {r_acc[11:0], hex_d[3:0]};
    // Plane bits of the paired code point: held high bits plus 0x10000.
    assign plane   = {1'b0, r_held[9:6]} + 5'd1;

    always_comb begin
        n_mode    = r_mode;
        n_hex     = r_hex;
        n_acc     = r_acc;
        n_held    = r_held;
        res       = '0;
        do_fail   = 1'b0;
        fail_code = ERR_NO_QUOTE;
        emit16    = 1'b0;
        emit21    = 1'b0;

        case (r_mode)
            MODE_STR: begin
                if (i_item.text_end) begin
                    do_fail   = 1'b1;
                    fail_code = ERR_UNCLOSED;
                end else if (i_item.in_byte == CH_QUOTE) begin
                    res.count             = 3'd1;
                    res.items[0].out_kind = KIND_CLOSE;
                    n_mode                = MODE_IDLE;
                end else if (i_item.in_byte == CH_BSLASH) begin
                    n_mode = MODE_ESC;
                end else if (i_item.in_byte < CH_SPACE) begin
                    do_fail   = 1'b1;
                    fail_code = ERR_CONTROL;
                end else begin
                    res.count             = 3'd1;
                    res.items[0].out_byte = i_item.in_byte;
                end
            end
            MODE_ESC: begin
                if (i_item.text_end) begin
                    do_fail   = 1'b1;
                    fail_code = ERR_UNCLOSED;
                end else begin
                    n_mode    = MODE_STR;
                    res.count = 3'd1;
                    case (i_item.in_byte)
                        CH_QUOTE, CH_BSLASH, CH_SLASH: res.items[0].out_byte = i_item.in_byte;
                        CH_B: res.items[0].out_byte = 8'h08;
                        CH_F: res.items[0].out_byte = 8'h0c;
                        CH_N: res.items[0].out_byte = 8'h0a;
                        CH_R: res.items[0].out_byte = 8'h0d;
                        CH_T: res.items[0].out_byte = 8'h09;
                        CH_U: begin
                            res.count = 3'd0;
                            n_mode    = MODE_HEX1;
                            n_hex     = 2'd0;
                            n_acc     = 16'd0;
                        end
                        default: begin
                            do_fail   = 1'b1;
                            fail_code = ERR_ESCAPE;
                        end
                    endcase
                end
            end
            MODE_HEX1, MODE_HEX2: begin
                if (!hex_ok) begin
                    do_fail   = 1'b1;
                    fail_code = (r_mode == MODE_HEX1) ? ERR_HEX : ERR_SURROGATE;
                end else if (r_hex != 2'd3) begin
                    n_hex = r_hex + 2'd1;
                    n_acc = acc_new;
                end else begin
                    n_hex = 2'd0;
                    n_acc = 16'd0;
                    if (r_mode == MODE_HEX1) begin
                        if (acc_new[15:10] == SURR_HIGH_TAG) begin
                            n_held = acc_new[9:0];
                            n_mode = MODE_WANT_BS;
                        end else begin
                            emit16 = 1'b1;
                            n_mode = MODE_STR;
                        end
                    end else if (acc_new[15:10] == SURR_LOW_TAG) begin
                        emit21 = 1'b1;
                        n_held = 10'd0;
                        n_mode = MODE_STR;
                    end else begin
                        do_fail   = 1'b1;
                        fail_code = ERR_SURROGATE;
                    end
                end
            end
            MODE_WANT_BS: begin
                if (!i_item.text_end && i_item.in_byte == CH_BSLASH) begin
                    n_mode = MODE_WANT_U;
                end else begin
                    do_fail   = 1'b1;
                    fail_code = ERR_SURROGATE;
                end
            end
            MODE_WANT_U: begin
                if (!i_item.text_end && i_item.in_byte == CH_U) begin
                    n_mode = MODE_HEX2;
                    n_hex  = 2'd0;
                    n_acc  = 16'd0;
                end else begin
                    do_fail   = 1'b1;
                    fail_code = ERR_SURROGATE;
                end
            end
            default: begin
                if (!i_item.text_end && i_item.in_byte == CH_QUOTE) begin
                    n_mode = MODE_STR;
                    n_hex  = 2'd0;
                    n_acc  = 16'd0;
                    n_held = 10'd0;
                end else begin
                    do_fail   = 1'b1;
                    fail_code = ERR_NO_QUOTE;
                end
            end
        endcase

        if (emit16) begin
            if (acc_new[15:7] == 9'd0) begin
                res.count             = 3'd1;
                res.items[0].out_byte = {1'b0, acc_new[6:0]};
            end else if (acc_new[15:11] == 5'd0) begin
                res.count             = 3'd2;
                res.items[0].out_byte = {3'b110, acc_new[10:6]};
                res.items[1].out_byte = {2'b10, acc_new[5:0]};
            end else begin
                res.count             = 3'd3;
                res.items[0].out_byte = {4'b1110, acc_new[15:12]};
                res.items[1].out_byte = {2'b10, acc_new[11:6]};
                res.items[2].out_byte = {2'b10, acc_new[5:0]};
            end
        end

        if (emit21) begin
            res.count             = 3'd4;
            res.items[0].out_byte = {5'b11110, plane[4:2]};
            res.items[1].out_byte = {2'b10, plane[1:0], r_held[5:2]};
            res.items[2].out_byte = {2'b10, r_held[1:0], acc_new[9:6]};
            res.items[3].out_byte = {2'b10, acc_new[5:0]};
        end

        if (do_fail) begin
            res                   = '0;
            res.count             = 3'd1;
            res.items[0].out_kind = KIND_ERR;
            res.items[0].err_code = fail_code;
            n_mode                = MODE_IDLE;
            n_hex                 = 2'd0;
            n_acc                 = 16'd0;
            n_held                = 10'd0;
        end

        for (int k = 0; k < MAX_RESULTS; k++) begin
            res.items[k].run_last = (res.count == CNT_W'(k + 1));
        end
    end

    assign o_res = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_hex  <= 2'd0;
            r_acc  <= 16'd0;
            r_held <= 10'd0;
        end else if (i_take) begin
            r_mode <= n_mode;
            r_hex  <= n_hex;
            r_acc  <= n_acc;
            r_held <= n_held;
        end
    end

    // Digits are only counted while a hex escape is being read.
    a_hex_in_escape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hex != 2'd0) |-> (r_mode == MODE_HEX1 || r_mode == MODE_HEX2))
        else $error("hex digit count outside a hex escape");

    // A held high surrogate only survives while its pair is awaited.
    a_held_in_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_held != 10'd0) |->
            (r_mode == MODE_WANT_BS || r_mode == MODE_WANT_U || r_mode == MODE_HEX2))
        else $error("high surrogate bits held outside a pair");

    // A four-byte sequence comes only from the second escape of a pair.
    a_four_from_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && res.count == 3'd4) |-> (r_mode == MODE_HEX2 && r_hex == 2'd3))
        else $error("four results outside a surrogate pair");

endmodule

// ===== hdl/jsu_outq.sv =====
// Result register: holds the results of one input item and hands them out in order.
// Depends on jsu_pkg.
module jsu_outq
    import jsu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_dec_res  i_res,
    input  logic      i_take,
    output logic      o_valid,
    output logic      o_last_going,
    output t_out_item o_item
);

    logic [CNT_W-1:0]            r_cnt, n_cnt;
    t_out_item [MAX_RESULTS-1:0] r_items, n_items;

    assign o_valid      = (r_cnt != '0);
    assign o_item       = r_items[0];
    // The buffer empties in this cycle when its only result is transferred.
    assign o_last_going = (r_cnt == CNT_W'(1)) && i_take;

    always_comb begin
        n_cnt   = r_cnt;
        n_items = r_items;
        if (i_load) begin
            n_cnt   = i_res.count;
            n_items = i_res.items;
        end else if (i_take) begin
            n_cnt = r_cnt - CNT_W'(1);
            for (int k = 0; k < MAX_RESULTS - 1; k++) begin
                n_items[k] = r_items[k + 1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_items <= n_items;
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_RESULTS))
        else $error("result count above the item limit");

    a_last_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == CNT_W'(1)) |-> r_items[0].run_last)
        else $error("final result of an item lacks the last mark");

    a_not_last_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt > CNT_W'(1)) |-> !r_items[0].run_last)
        else $error("last mark on a result with more to follow");

endmodule
